// File: rtl/acs_pkg.sv
// ----------------------------------------------------------------------------
// Alignment column site classifier package
// Widths, codes, result types and the character coding shared by the block.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int TALLY_W     = 13;
    localparam int NUM_CODES   = 22;
    localparam int CODE_W      = $clog2(NUM_CODES);
    localparam int OCC_W       = 2;
    localparam int MAX_SPECIES = 4096;
    localparam int TALLY_CAP_I = (MAX_SPECIES > 8191) ? 8191 : MAX_SPECIES;
    localparam int PRODUCT_W   = TALLY_W + 4;

    localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_W'(TALLY_CAP_I);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEQ_TYPE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_MODE = 1'd1;

    // Alphabets.
    localparam logic SEQ_NUC  = 1'b0;
    localparam logic SEQ_PROT = 1'b1;

    // Keep modes.
    localparam logic [1:0] KEEP_ALL  = 2'd0;
    localparam logic [1:0] KEEP_VAR  = 2'd1;
    localparam logic [1:0] KEEP_INFO = 2'd2;

    // Occupancy classes.
    localparam logic [OCC_W-1:0] OCC_NONE = 2'd0;
    localparam logic [OCC_W-1:0] OCC_LOW  = 2'd1;
    localparam logic [OCC_W-1:0] OCC_HALF = 2'd2;
    localparam logic [OCC_W-1:0] OCC_HIGH = 2'd3;

    // Codes that count as states, and codes that are definite residues.
    localparam logic [NUM_CODES-1:0] NUC_STATE_MASK  = 22'h000117;
    localparam logic [NUM_CODES-1:0] PROT_STATE_MASK = 22'h1FFFFF;
    localparam logic [NUM_CODES-1:0] NUC_KNOWN_MASK  = 22'h000116;
    localparam logic [NUM_CODES-1:0] PROT_KNOWN_MASK = 22'h1FFFFE;

    typedef struct packed {
        logic                valid;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } stage_t;

    typedef struct packed {
        logic               hit;
        logic [CODE_W-1:0]  code;
        logic               present;
        logic               known;
    } code_info_t;

    typedef struct packed {
        logic [OCC_W-1:0]   occupancy;
        logic [TALLY_W-1:0] present_count;
        logic [TALLY_W-1:0] known_count;
        logic               variable;
        logic               informative;
        logic               kept;
        logic               bad_char;
    } result_t;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
        return (v < TALLY_CAP) ? v + TALLY_W'(1) : v;
    endfunction

    function automatic code_info_t classify(input logic [SYMBOL_W-1:0] raw,
                                            input logic seq_type);
        logic [SYMBOL_W-1:0]  c;
        code_info_t           info;
        logic [NUM_CODES-1:0] known_mask;
        c          = raw;
        info.hit   = 1'b1;
        info.code  = '0;
        if (raw >= "a" && raw <= "z")
        begin
            c = raw - SYMBOL_W'(32);
        end
        if (seq_type == SEQ_NUC)
        begin
            unique case (c) inside
                "A":           info.code = CODE_W'(8);
                "C":           info.code = CODE_W'(4);
                "G":           info.code = CODE_W'(2);
                "T", "U":      info.code = CODE_W'(1);
                "*", "-", "$": info.code = CODE_W'(0);
                " ", "X", "?": info.code = CODE_W'(16);
                "N":           info.code = CODE_W'(15);
                "R":           info.code = CODE_W'(10);
                "Y":           info.code = CODE_W'(5);
                "M":           info.code = CODE_W'(12);
                "W":           info.code = CODE_W'(9);
                "S":           info.code = CODE_W'(6);
                "K":           info.code = CODE_W'(3);
                "D":           info.code = CODE_W'(11);
                "H":           info.code = CODE_W'(13);
                "V":           info.code = CODE_W'(14);
                "B":           info.code = CODE_W'(7);
                default:       info.hit  = 1'b0;
            endcase
            known_mask = NUC_KNOWN_MASK;
        end
        else
        begin
            unique case (c) inside
                "*", "-", "$":           info.code = CODE_W'(0);
                " ", "?", "X", "B", "Z": info.code = CODE_W'(21);
                "A":     info.code = CODE_W'(1);
                "C":     info.code = CODE_W'(2);
                "D":     info.code = CODE_W'(3);
                "E":     info.code = CODE_W'(4);
                "F":     info.code = CODE_W'(5);
                "G":     info.code = CODE_W'(6);
                "H":     info.code = CODE_W'(7);
                "I":     info.code = CODE_W'(8);
                "K":     info.code = CODE_W'(9);
                "L":     info.code = CODE_W'(10);
                "M":     info.code = CODE_W'(11);
                "N":     info.code = CODE_W'(12);
                "P":     info.code = CODE_W'(13);
                "Q":     info.code = CODE_W'(14);
                "R":     info.code = CODE_W'(15);
                "S":     info.code = CODE_W'(16);
                "T":     info.code = CODE_W'(17);
                "V":     info.code = CODE_W'(18);
                "W":     info.code = CODE_W'(19);
                "Y":     info.code = CODE_W'(20);
                default: info.hit  = 1'b0;
            endcase
            known_mask = PROT_KNOWN_MASK;
        end
        info.present = info.hit && (c != "*") && (c != " ") && (c != "?")
                       && (c != "$") && (c != "-");
        info.known   = info.hit && known_mask[info.code];
        return info;
    endfunction

endpackage

// File: rtl/acs_item_if.sv
// ----------------------------------------------------------------------------
// Column character channel
// Valid/ready channel that carries one species character and the last mark.
// ----------------------------------------------------------------------------
interface acs_item_if;
    logic                          valid;
    logic                          ready;
    logic [acs_pkg::SYMBOL_W-1:0]  symbol;
    logic                          last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

// File: rtl/acs_result_if.sv
// ----------------------------------------------------------------------------
// Column result channel
// Valid/ready channel that carries the classification of one column.
// ----------------------------------------------------------------------------
interface acs_result_if;
    logic                         valid;
    logic                         ready;
    logic [acs_pkg::OCC_W-1:0]    occupancy;
    logic [acs_pkg::TALLY_W-1:0]  present_count;
    logic [acs_pkg::TALLY_W-1:0]  known_count;
    logic                         variable;
    logic                         informative;
    logic                         kept;
    logic                         bad_char;

    modport source (output valid, output occupancy, output present_count,
                    output known_count, output variable, output informative,
                    output kept, output bad_char, input ready);
    modport sink   (input valid, input occupancy, input present_count,
                    input known_count, input variable, input informative,
                    input kept, input bad_char, output ready);
endinterface

// File: rtl/acs_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted character until the tally stage takes it.
// ----------------------------------------------------------------------------
module acs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    acs_item_if.sink          item,
    input  logic              advance,
    output acs_pkg::stage_t   stage
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [acs_pkg::SYMBOL_W-1:0]  symbol_reg;
    logic                          last_reg;
    logic                          take;

    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            symbol_reg <= item.symbol;
            last_reg   <= item.last;
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.symbol = symbol_reg;
    assign stage.last   = last_reg;

endmodule

// File: rtl/acs_tally.sv
// ----------------------------------------------------------------------------
// Column tally
// Codes each character, keeps the per-code presence counts and tallies, and
// forms the column classification on the last character.
// ----------------------------------------------------------------------------
module acs_tally (
    input  logic              clk,
    input  logic              rst_n,
    input  acs_pkg::stage_t   stage,
    input  logic              advance,
    input  logic              seq_type,
    input  logic [1:0]        keep_mode,
    output acs_pkg::result_t  result
);

    localparam int NC = acs_pkg::NUM_CODES;
    localparam int TW = acs_pkg::TALLY_W;
    localparam int PW = acs_pkg::PRODUCT_W;

    logic [1:0]     seen_reg [NC];
    logic [1:0]     seen_next [NC];
    logic [TW-1:0]  species_reg;
    logic [TW-1:0]  species_next;
    logic [TW-1:0]  present_reg;
    logic [TW-1:0]  present_next;
    logic [TW-1:0]  known_reg;
    logic [TW-1:0]  known_next;
    logic           error_reg;
    logic           error_next;

    acs_pkg::code_info_t        info;
    logic [NC-1:0]              state_mask;
    logic [NC-1:0]              once;
    logic [NC-1:0]              twice;
    logic [PW-1:0]              ten_p;
    logic [PW-1:0]              nine_s;
    logic [PW-1:0]              p_wide;
    logic [PW-1:0]              s_wide;
    logic [PW-1:0]              twice_p;
    logic                       var_flag;
    logic                       info_flag;
    logic [acs_pkg::OCC_W-1:0]  occupancy;
    logic                       kept_flag;

    assign info         = acs_pkg::classify(stage.symbol, seq_type);
    assign species_next = acs_pkg::sat_inc(species_reg);
    assign present_next = info.present ? acs_pkg::sat_inc(present_reg) : present_reg;
    assign known_next   = info.known ? acs_pkg::sat_inc(known_reg) : known_reg;
    assign error_next   = error_reg || !info.hit;
    assign state_mask   = (seq_type == acs_pkg::SEQ_NUC) ? acs_pkg::NUC_STATE_MASK
                                                         : acs_pkg::PROT_STATE_MASK;

    always_comb
    begin
        for (int j = 0; j < NC; j++)
        begin
            seen_next[j] = seen_reg[j];
            if (info.hit && (info.code == acs_pkg::CODE_W'(j)) && (seen_reg[j] != 2'd3))
            begin
                seen_next[j] = seen_reg[j] + 2'd1;
            end
            once[j]  = state_mask[j] && (seen_next[j] != 2'd0);
            twice[j] = state_mask[j] && seen_next[j][1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NC; j++)
            begin
                seen_reg[j] <= 2'd0;
            end
            species_reg <= '0;
            present_reg <= '0;
            known_reg   <= '0;
            error_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (stage.last)
            begin
                for (int j = 0; j < NC; j++)
                begin
                    seen_reg[j] <= 2'd0;
                end
                species_reg <= '0;
                present_reg <= '0;
                known_reg   <= '0;
                error_reg   <= 1'b0;
            end
            else
            begin
                seen_reg    <= seen_next;
                species_reg <= species_next;
                present_reg <= present_next;
                known_reg   <= known_next;
                error_reg   <= error_next;
            end
        end
    end

    // Exact forms of the ninety percent and half thresholds.
    assign p_wide  = PW'(present_next);
    assign s_wide  = PW'(species_next);
    assign ten_p   = (p_wide << 3) + (p_wide << 1);
    assign nine_s  = (s_wide << 3) + s_wide;
    assign twice_p = p_wide << 1;

    always_comb
    begin
        if (present_next == '0)
        begin
            occupancy = acs_pkg::OCC_NONE;
        end
        else if (ten_p >= nine_s)
        begin
            occupancy = acs_pkg::OCC_HIGH;
        end
        else if (twice_p >= s_wide)
        begin
            occupancy = acs_pkg::OCC_HALF;
        end
        else
        begin
            occupancy = acs_pkg::OCC_LOW;
        end
    end

    // A vector has more than one bit set when clearing its lowest set bit
    // leaves something behind.
    assign var_flag  = (present_next != '0) && ((once & (once - NC'(1))) != '0);
    assign info_flag = var_flag && ((twice & (twice - NC'(1))) != '0);

    always_comb
    begin
        if (present_next == '0)
        begin
            kept_flag = 1'b0;
        end
        else
        begin
            case (keep_mode)
                acs_pkg::KEEP_ALL:  kept_flag = 1'b1;
                acs_pkg::KEEP_INFO: kept_flag = info_flag;
                default:            kept_flag = var_flag;
            endcase
        end
    end

    assign result.occupancy     = occupancy;
    assign result.present_count = present_next;
    assign result.known_count   = known_next;
    assign result.variable      = var_flag;
    assign result.informative   = info_flag;
    assign result.kept          = kept_flag;
    assign result.bad_char      = error_next;

endmodule

// File: rtl/acs_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one column result until the downstream side takes it.
// ----------------------------------------------------------------------------
module acs_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  acs_pkg::result_t  data,
    output logic              can_load,
    acs_result_if.source      result
);

    logic              valid_reg;
    logic              valid_next;
    acs_pkg::result_t  data_reg;

    assign can_load   = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result.valid         = valid_reg;
    assign result.occupancy     = data_reg.occupancy;
    assign result.present_count = data_reg.present_count;
    assign result.known_count   = data_reg.known_count;
    assign result.variable      = data_reg.variable;
    assign result.informative   = data_reg.informative;
    assign result.kept          = data_reg.kept;
    assign result.bad_char      = data_reg.bad_char;

endmodule

// File: rtl/alignment_column_site_classifier_top.sv
// ----------------------------------------------------------------------------
// Alignment column site classifier
// Classifies an alignment column, one species character a cycle unless stalled.
//
//   Channel   Direction  Payload                                   Transfer
//   item      in         symbol, last                              valid & ready
//   result    out        occupancy, counts, variable, informative, valid & ready
//                        kept, bad_char
//   cfg       in         cfg_index, cfg_data                       cfg_we
//
// One character is taken every cycle while no last character waits in the
// input register. Each character is registered in the input register; the
// last character of a column loads the tally result into the result register
// as it leaves the input register. Reset clears the tallies and the
// configuration. Only a last character waits on a full, stalled result register.
// ----------------------------------------------------------------------------
module alignment_column_site_classifier_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [acs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]     cfg_data,
    acs_item_if.sink                           item,
    acs_result_if.source                       result
);

    logic              seq_type_reg;
    logic [1:0]        keep_mode_reg;
    acs_pkg::stage_t   stage;
    acs_pkg::result_t  column_result;
    logic              can_load;
    logic              advance;
    logic              load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_type_reg  <= acs_pkg::SEQ_NUC;
            keep_mode_reg <= acs_pkg::KEEP_ALL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acs_pkg::CFG_SEQ_TYPE:  seq_type_reg  <= cfg_data[0];
                acs_pkg::CFG_KEEP_MODE: keep_mode_reg <= cfg_data[1:0];
                default:                ;
            endcase
        end
    end

    assign advance = stage.valid && (!stage.last || can_load);
    assign load    = advance && stage.last;

    acs_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    acs_tally u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .advance   (advance),
        .seq_type  (seq_type_reg),
        .keep_mode (keep_mode_reg),
        .result    (column_result)
    );

    acs_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .data     (column_result),
        .can_load (can_load),
        .result   (result)
    );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Alignment column site classifier testbench
// Streams alignment columns through the block under several alphabet and
// keep-mode settings. A directed set covers gaps, unknown and ambiguous marks,
// lower case, bad characters and columns on the occupancy boundaries. Random
// columns follow, sent in bursts against a stalling receiver. Each column
// result is checked field by field against a built-in prediction of the column
// classification.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KEEP_SPARE  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         NUM_PHASES  = 8;
    localparam int         RANDOM_ITEMS_PER_PHASE = 170;

    localparam string NUC_ALPHABET  = "ACGTU*-$ X?NRYMWSKDHVB";
    localparam string NUC_BASES     = "ACGTU";
    localparam string NUC_STATES    = "ACGTU-$*";
    localparam string PROT_ALPHABET = "ACDEFGHIKLMNPQRSTVWY*-$ ?XBZ";
    localparam string PROT_RESIDUES = "ACDEFGHIKLMNPQRSTVWY";
    localparam string PROT_STATES   = "ACDEFGHIKLMNPQRSTVWY-";
    localparam string GAP_MARKS     = "*-$";
    localparam string ABSENT_MARKS  = "* ?$-";

    typedef struct packed {
        logic [acs_pkg::SYMBOL_W-1:0] symbol;
        logic                         last;
    } column_char_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [acs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [acs_pkg::CFG_DATA_W-1:0]  cfg_data;

    acs_item_if   item_ch ();
    acs_result_if result_ch ();

    alignment_column_site_classifier_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    column_char_t      pending_chars[$];
    acs_pkg::result_t  expected_sites[$];

    logic                        model_prot = 1'b0;
    logic [1:0]                  model_keep = acs_pkg::KEEP_ALL;
    int                          state_hits[256];
    logic [acs_pkg::TALLY_W-1:0] present_cnt  = '0;
    logic [acs_pkg::TALLY_W-1:0] known_cnt    = '0;
    logic [acs_pkg::TALLY_W-1:0] species_cnt  = '0;
    logic                        alphabet_error = 1'b0;

    int   mismatches  = 0;
    int   idle_cycles = 0;
    logic item_taken  = 1'b0;
    int   send_gap    = 0;
    int   send_burst  = 0;
    int   stall_phase = 0;
    logic [15:0] stall_bits = '1;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic bit in_set(logic [7:0] c, string s);
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == c)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [acs_pkg::TALLY_W-1:0] bump(logic [acs_pkg::TALLY_W-1:0] v);
        return (v < acs_pkg::TALLY_CAP_I) ? v + 1'b1 : v;
    endfunction

    function automatic void clear_column();
        foreach (state_hits[k])
        begin
            state_hits[k] = 0;
        end
        present_cnt    = '0;
        known_cnt      = '0;
        species_cnt    = '0;
        alphabet_error = 1'b0;
    endfunction

    function automatic void absorb_character(logic [7:0] raw, logic last);
        logic [7:0]        c;
        logic [7:0]        key;
        bit                hit;
        bit                known;
        int                n1;
        int                n2;
        int                p;
        int                s;
        acs_pkg::result_t  site;
        c  = raw;
        n1 = 0;
        n2 = 0;
        if (c >= "a" && c <= "z")
        begin
            c = c - 8'd32;
        end
        species_cnt = bump(species_cnt);
        hit   = in_set(c, model_prot ? PROT_ALPHABET : NUC_ALPHABET);
        known = hit && in_set(c, model_prot ? PROT_RESIDUES : NUC_BASES);
        if (!hit)
        begin
            alphabet_error = 1'b1;
        end
        else
        begin
            if (!in_set(c, ABSENT_MARKS))
            begin
                present_cnt = bump(present_cnt);
            end
            key = 8'd0;
            if (known)
            begin
                known_cnt = bump(known_cnt);
                key = (c == "U") ? "T" : c;
            end
            else if (in_set(c, GAP_MARKS))
            begin
                key = "-";
            end
            if (key != 8'd0 && state_hits[key] < 3)
            begin
                state_hits[key]++;
            end
        end
        if (!last)
        begin
            return;
        end
        foreach (state_hits[k])
        begin
            if (state_hits[k] >= 1)
            begin
                n1++;
            end
            if (state_hits[k] >= 2)
            begin
                n2++;
            end
        end
        p = present_cnt;
        s = species_cnt;
        if (p == 0)
        begin
            site.occupancy = acs_pkg::OCC_NONE;
        end
        else if (10 * p >= 9 * s)
        begin
            site.occupancy = acs_pkg::OCC_HIGH;
        end
        else if (2 * p >= s)
        begin
            site.occupancy = acs_pkg::OCC_HALF;
        end
        else
        begin
            site.occupancy = acs_pkg::OCC_LOW;
        end
        site.present_count = present_cnt;
        site.known_count   = known_cnt;
        site.variable      = (p != 0) && (n1 > 1);
        site.informative   = site.variable && (n2 > 1);
        site.bad_char      = alphabet_error;
        if (p == 0)
        begin
            site.kept = 1'b0;
        end
        else if (model_keep == acs_pkg::KEEP_ALL)
        begin
            site.kept = 1'b1;
        end
        else if (model_keep == acs_pkg::KEEP_INFO)
        begin
            site.kept = site.informative;
        end
        else
        begin
            site.kept = site.variable;
        end
        expected_sites.push_back(site);
        clear_column();
    endfunction

    function automatic void push_char(logic [7:0] c, logic last);
        column_char_t ch;
        ch.symbol = c;
        ch.last   = last;
        pending_chars.push_back(ch);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i], i == s.len() - 1);
        end
    endfunction

    function automatic void queue_random_columns(int budget);
        int         added;
        int         len;
        int         style;
        int         r;
        logic [7:0] pal[3];
        logic [7:0] c;
        string      alphabet;
        added    = 0;
        alphabet = model_prot ? PROT_ALPHABET : NUC_ALPHABET;
        while (added < budget)
        begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            style = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++)
            begin
                pal[k] = (style == 0) ? pick(ABSENT_MARKS)
                                      : pick(model_prot ? PROT_STATES : NUC_STATES);
            end
            for (int k = 0; k < len; k++)
            begin
                r = $urandom_range(0, 99);
                if (style == 9 || r >= 93)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                else if (r < 65)
                begin
                    c = pal[$urandom_range(0, 2)];
                end
                else
                begin
                    c = pick(alphabet);
                end
                if (c >= "A" && c <= "Z" && $urandom_range(0, 3) == 0)
                begin
                    c = c + 8'd32;
                end
                push_char(c, (k == len - 1) || (style == 9 && $urandom_range(0, 5) == 0));
            end
            added += len;
        end
    endfunction

    task automatic write_register(logic [acs_pkg::CFG_INDEX_W-1:0] index,
                                  logic [acs_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == acs_pkg::CFG_SEQ_TYPE)
        begin
            model_prot = data[0];
        end
        else
        begin
            model_keep = data;
        end
    endtask

    task automatic wait_for_drain(int settle);
        while (pending_chars.size() != 0 || item_ch.valid || expected_sites.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // Sender: bursts of transfers separated by random gaps.
    always @(negedge clk)
    begin
        column_char_t nxt;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else if (!item_ch.valid || item_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                nxt = pending_chars.pop_front();
                item_ch.valid  <= 1'b1;
                item_ch.symbol <= nxt.symbol;
                item_ch.last   <= nxt.last;
                if (send_burst > 0)
                begin
                    send_burst--;
                end
                if (send_burst == 0)
                begin
                    send_burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 16);
                    send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a 16-bit pattern that is redrawn once all its bits are used.
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_bits = '1;
                1: stall_bits = 16'($urandom & $urandom);
                default: stall_bits = 16'($urandom);
            endcase
            stall_phase = 16;
        end
        stall_phase--;
        result_ch.ready <= stall_bits[stall_phase];
    end

    always @(posedge clk)
    begin
        acs_pkg::result_t got;
        acs_pkg::result_t want;
        item_taken = item_ch.valid && item_ch.ready;
        if (item_taken)
        begin
            absorb_character(item_ch.symbol, item_ch.last);
        end
        if (result_ch.valid && result_ch.ready)
        begin
            got.occupancy     = result_ch.occupancy;
            got.present_count = result_ch.present_count;
            got.known_count   = result_ch.known_count;
            got.variable      = result_ch.variable;
            got.informative   = result_ch.informative;
            got.kept          = result_ch.kept;
            got.bad_char      = result_ch.bad_char;
            if (expected_sites.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: occ=%0d present=%0d known=%0d",
                             got.occupancy, got.present_count, got.known_count);
                end
            end
            else
            begin
                want = expected_sites.pop_front();
                if (got.occupancy !== want.occupancy
                    || got.present_count !== want.present_count
                    || got.known_count !== want.known_count
                    || got.variable !== want.variable
                    || got.informative !== want.informative
                    || got.kept !== want.kept
                    || got.bad_char !== want.bad_char)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: expected occ=%0d pres=%0d known=%0d",
                               want.occupancy, want.present_count, want.known_count);
                        $display(" var=%0b info=%0b kept=%0b bad=%0b",
                                 want.variable, want.informative, want.kept,
                                 want.bad_char);
                        $write("          actual   occ=%0d pres=%0d known=%0d",
                               got.occupancy, got.present_count, got.known_count);
                        $display(" var=%0b info=%0b kept=%0b bad=%0b",
                                 got.variable, got.informative, got.kept,
                                 got.bad_char);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic       seq_plan[NUM_PHASES];
        logic [1:0] keep_plan[NUM_PHASES];
        seq_plan  = '{acs_pkg::SEQ_NUC, acs_pkg::SEQ_PROT,
                      acs_pkg::SEQ_NUC, acs_pkg::SEQ_PROT,
                      acs_pkg::SEQ_NUC, acs_pkg::SEQ_PROT,
                      acs_pkg::SEQ_NUC, acs_pkg::SEQ_PROT};
        keep_plan = '{acs_pkg::KEEP_ALL, acs_pkg::KEEP_INFO,
                      acs_pkg::KEEP_VAR, KEEP_SPARE,
                      acs_pkg::KEEP_INFO, acs_pkg::KEEP_ALL,
                      KEEP_SPARE, acs_pkg::KEEP_VAR};
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = acs_pkg::CFG_SEQ_TYPE;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.symbol  = '0;
        item_ch.last    = 1'b0;
        result_ch.ready = 1'b0;
        clear_column();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_register(acs_pkg::CFG_SEQ_TYPE, {1'($urandom_range(0, 1)), seq_plan[ph]});
            write_register(acs_pkg::CFG_KEEP_MODE, keep_plan[ph]);
            if (ph == 0)
            begin
                push_text("A");
                push_text("-$*");
                push_text("aaGG");
                push_text("X? NRybU");
                push_char(8'h00, 1'b0);
                push_char(8'hFF, 1'b0);
                push_text("T");
            end
            else if (ph == 1)
            begin
                push_text("BZx");
                push_text("KkLl-");
            end
            else if (ph == 2)
            begin
                // The first column sits exactly on the half threshold and the
                // second exactly on the ninety percent threshold.
                for (int k = 0; k < 100; k++)
                begin
                    push_char("-", 1'b0);
                end
                for (int k = 0; k < 100; k++)
                begin
                    push_char(pick("ACac"), k == 99);
                end
                for (int k = 0; k < 45; k++)
                begin
                    push_char("g", 1'b0);
                end
                for (int k = 0; k < 5; k++)
                begin
                    push_char("?", k == 4);
                end
            end
            queue_random_columns(RANDOM_ITEMS_PER_PHASE);
            wait_for_drain(4);
        end

        wait_for_drain(8);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
